>>> rtl/core/onewire_bus_master_defines.svh
// ----------------------------------------------------------------------------
// onewire_bus_master_defines.svh
// Assertion macros used by the single-wire bus master engine.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_BUS_MASTER_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OWBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OWBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, codes, register defaults and the CRC-8 fold of the bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

   localparam int CFG_W     = 10;
   localparam int NUM_CFG   = 7;
   localparam int CFG_IDX_W = 3;

   localparam logic [7:0] CRC_POLY = 8'h8C;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_RESET_LOW     = 3'd0,
      CFG_PRESENCE_WAIT = 3'd1,
      CFG_RECOVERY      = 3'd2,
      CFG_SHORT_LOW     = 3'd3,
      CFG_LONG_LOW      = 3'd4,
      CFG_READ_SAMPLE   = 3'd5,
      CFG_READ_TAIL     = 3'd6
   } cfg_index_type;

   localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd500;
   localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd100;
   localparam logic [CFG_W-1:0] RST_RECOVERY      = 10'd500;
   localparam logic [CFG_W-1:0] RST_SHORT_LOW     = 10'd5;
   localparam logic [CFG_W-1:0] RST_LONG_LOW      = 10'd65;
   localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd5;
   localparam logic [CFG_W-1:0] RST_READ_TAIL     = 10'd55;

   typedef enum logic [1:0] {
      REQ_TICK      = 2'd0,
      REQ_BUS_RESET = 2'd1,
      REQ_WRITE     = 2'd2,
      REQ_READ      = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RECOVERY = 4'd3,
      PH_WR_LOW   = 4'd4,
      PH_WR_REL   = 4'd5,
      PH_RD_LOW   = 4'd6,
      PH_RD_WAIT  = 4'd7,
      PH_RD_TAIL  = 4'd8
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] reset_low_ticks;
      logic [CFG_W-1:0] presence_wait_ticks;
      logic [CFG_W-1:0] recovery_ticks;
      logic [CFG_W-1:0] short_low_ticks;
      logic [CFG_W-1:0] long_low_ticks;
      logic [CFG_W-1:0] read_sample_ticks;
      logic [CFG_W-1:0] read_tail_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] tx_byte;
      logic       line_level;
   } req_item_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] rx_byte;
      logic [7:0] crc_value;
      logic       rejected;
   } rsp_item_type;

   // reflected CRC-8, one byte, LSB first
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/owbm_if.sv
// ----------------------------------------------------------------------------
// owbm_req_if / owbm_rsp_if
// Valid/ready channels for bus master commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface owbm_req_if
   import owbm_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] tx_byte;
   logic       line_level;

   modport source (output valid, output req_type, output tx_byte, output line_level,
                   input ready);
   modport sink   (input valid, input req_type, input tx_byte, input line_level,
                   output ready);
endinterface

interface owbm_rsp_if
   import owbm_pkg::*;
();
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       presence;
   logic [7:0] rx_byte;
   logic [7:0] crc_value;
   logic       rejected;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output rx_byte, output crc_value, output rejected,
                   input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input presence, input rx_byte, input crc_value, input rejected,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/core/owbm_csr.sv
// ----------------------------------------------------------------------------
// owbm_csr
// Timing register file, write-only, reset to the standard slot timings.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_csr
   import owbm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CFG_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CFG_RESET_LOW:     cfg_in.reset_low_ticks     = csr_wdata;
            CFG_PRESENCE_WAIT: cfg_in.presence_wait_ticks = csr_wdata;
            CFG_RECOVERY:      cfg_in.recovery_ticks      = csr_wdata;
            CFG_SHORT_LOW:     cfg_in.short_low_ticks     = csr_wdata;
            CFG_LONG_LOW:      cfg_in.long_low_ticks      = csr_wdata;
            CFG_READ_SAMPLE:   cfg_in.read_sample_ticks   = csr_wdata;
            CFG_READ_TAIL:     cfg_in.read_tail_ticks     = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RST_RESET_LOW;
         cfg_ff.presence_wait_ticks <= RST_PRESENCE_WAIT;
         cfg_ff.recovery_ticks      <= RST_RECOVERY;
         cfg_ff.short_low_ticks     <= RST_SHORT_LOW;
         cfg_ff.long_low_ticks      <= RST_LONG_LOW;
         cfg_ff.read_sample_ticks   <= RST_READ_SAMPLE;
         cfg_ff.read_tail_ticks     <= RST_READ_TAIL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/owbm_in_reg.sv
// ----------------------------------------------------------------------------
// owbm_in_reg
// Input register: holds one command or tick until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_in_reg
   import owbm_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   owbm_req_if.sink    req_chan,
   input  wire logic   take,
   output logic        item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.req_type   <= req_chan.req_type;
         item_ff.tx_byte    <= req_chan.tx_byte;
         item_ff.line_level <= req_chan.line_level;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

>>> rtl/core/owbm_engine.sv
// ----------------------------------------------------------------------------
// owbm_engine
// Slot sequencer: phase, interval timer, bit counter, shifter and CRC.
// ----------------------------------------------------------------------------
`default_nettype none

`include "onewire_bus_master_defines.svh"

module owbm_engine
   import owbm_pkg::*;
#(
   parameter int TIMER_WIDTH = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   output rsp_item_type      result
);

   localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
   localparam logic [TIMER_WIDTH-1:0] TMAX   = {TIMER_WIDTH{1'b1}};
   localparam logic [CMP_W-1:0]       TMAX_W = CMP_W'(TMAX);

   function automatic logic [TIMER_WIDTH-1:0] sat_ticks(input logic [CFG_W-1:0] ticks);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(ticks);
      if (wide > TMAX_W) begin
         return TMAX;
      end
      return TIMER_WIDTH'(wide);
   endfunction

   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [2:0]             bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in;
   logic [7:0]             crc_ff, crc_in;
   logic                   pres_ff, pres_in;
   logic [7:0]             rx_ff, rx_in;
   logic                   done;
   logic                   rej;
   logic                   busy;
   logic [2:0]             bit_nxt;

   assign busy    = (phase_ff != PH_IDLE);
   assign bit_nxt = bit_ff + 3'd1;

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      crc_in   = crc_ff;
      pres_in  = pres_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      rej      = 1'b0;
      if (item.req_type == REQ_TICK) begin
         if (busy) begin
            if (timer_ff > TIMER_WIDTH'(1)) begin
               timer_in = timer_ff - TIMER_WIDTH'(1);
            end else begin
               timer_in = '0;
               case (phase_ff)
                  PH_RST_LOW: begin
                     phase_in = PH_RST_WAIT;
                     timer_in = sat_ticks(cfg.presence_wait_ticks);
                  end
                  PH_RST_WAIT: begin
                     if (!item.line_level) begin
                        pres_in  = 1'b1;
                        phase_in = PH_RECOVERY;
                        timer_in = sat_ticks(cfg.recovery_ticks);
                     end else begin
                        pres_in  = 1'b0;
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end
                  end
                  PH_RECOVERY: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_WR_LOW: begin
                     phase_in = PH_WR_REL;
                     timer_in = shift_ff[bit_ff] ? sat_ticks(cfg.long_low_ticks)
                                                 : sat_ticks(cfg.short_low_ticks);
                  end
                  PH_WR_REL: begin
                     if (bit_ff == 3'd7) begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        bit_in   = bit_nxt;
                        phase_in = PH_WR_LOW;
                        timer_in = shift_ff[bit_nxt] ? sat_ticks(cfg.short_low_ticks)
                                                     : sat_ticks(cfg.long_low_ticks);
                     end
                  end
                  PH_RD_LOW: begin
                     phase_in = PH_RD_WAIT;
                     timer_in = sat_ticks(cfg.read_sample_ticks);
                  end
                  PH_RD_WAIT: begin
                     shift_in = {item.line_level, shift_ff[7:1]};
                     phase_in = PH_RD_TAIL;
                     timer_in = sat_ticks(cfg.read_tail_ticks);
                  end
                  PH_RD_TAIL: begin
                     if (bit_ff == 3'd7) begin
                        rx_in    = shift_ff;
                        crc_in   = crc8_fold(crc_ff, shift_ff);
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        bit_in   = bit_nxt;
                        phase_in = PH_RD_LOW;
                        timer_in = sat_ticks(cfg.short_low_ticks);
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end else if (busy) begin
         rej = 1'b1;
      end else begin
         bit_in = 3'd0;
         case (item.req_type)
            REQ_BUS_RESET: begin
               crc_in   = 8'h00;
               pres_in  = 1'b0;
               phase_in = PH_RST_LOW;
               timer_in = sat_ticks(cfg.reset_low_ticks);
            end
            REQ_WRITE: begin
               shift_in = item.tx_byte;
               phase_in = PH_WR_LOW;
               timer_in = item.tx_byte[0] ? sat_ticks(cfg.short_low_ticks)
                                          : sat_ticks(cfg.long_low_ticks);
            end
            REQ_READ: begin
               shift_in = 8'h00;
               phase_in = PH_RD_LOW;
               timer_in = sat_ticks(cfg.short_low_ticks);
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'h00;
         crc_ff   <= 8'h00;
         pres_ff  <= 1'b0;
         rx_ff    <= 8'h00;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         crc_ff   <= crc_in;
         pres_ff  <= pres_in;
         rx_ff    <= rx_in;
      end
   end

   always_comb begin
      result.drive_low = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                         (phase_in == PH_RD_LOW);
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.presence  = pres_in;
      result.rx_byte   = rx_in;
      result.crc_value = crc_in;
      result.rejected  = rej;
   end

   `OWBM_ASSERT_NOW(a_reject_only_busy, clock, reset, step && rej, busy, "reject while idle")
   `OWBM_ASSERT_NEXT(a_done_to_idle, clock, reset, step && done,
                     phase_ff == PH_IDLE, "done but not idle")
   `OWBM_ASSERT_NOW(a_drive_implies_busy, clock, reset, step && result.drive_low,
                    result.busy_res, "drive while idle")
   `OWBM_ASSERT_NEXT(a_bus_reset_clears, clock, reset,
                     step && !busy && (item.req_type == REQ_BUS_RESET),
                     (crc_ff == 8'h00) && !pres_ff && (phase_ff == PH_RST_LOW),
                     "bus reset start")

endmodule

`default_nettype wire

>>> rtl/core/owbm_out_reg.sv
// ----------------------------------------------------------------------------
// owbm_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_out_reg
   import owbm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire rsp_item_type result,
   output logic              free,
   owbm_rsp_if.source        rsp_chan
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.drive_low = data_ff.drive_low;
   assign rsp_chan.busy_res  = data_ff.busy_res;
   assign rsp_chan.done_res  = data_ff.done_res;
   assign rsp_chan.presence  = data_ff.presence;
   assign rsp_chan.rx_byte   = data_ff.rx_byte;
   assign rsp_chan.crc_value = data_ff.crc_value;
   assign rsp_chan.rejected  = data_ff.rejected;

endmodule

`default_nettype wire

>>> rtl/core/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master
// Single-wire bus master: bus reset with presence detect, byte write and
// byte read with a running CRC-8, paced by one-microsecond tick items.
//
//   channel    dir   handshake          contents
//   req_chan   in    valid/ready        req_type, tx_byte, line_level
//   rsp_chan   out   valid/ready        drive_low .. rejected, one per item
//   csr_*      in    csr_we only        csr_index, csr_wdata (timing regs)
//
// One item per clock cycle while the result register is free; the engine's
// single state update is the only step per item. Items are registered in
// the input register and results in the result register. A stalled result
// holds the engine while the input register still takes one more item. Reset
// is synchronous and restores the default timings; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_bus_master
   import owbm_pkg::*;
#(
   parameter int TIMER_WIDTH = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   owbm_req_if.sink                  req_chan,
   owbm_rsp_if.source                rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CFG_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   cfg_type      cfg;
   req_item_type item;
   rsp_item_type result;
   logic         item_valid;
   logic         out_free;
   logic         step;

   assign step = item_valid && out_free;

   owbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owbm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   owbm_engine #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   owbm_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
